>>> design/bale_pkg.sv
// ============================================================================
// bale_pkg: shared constants for the bounded array list engine
// Mode and status codes, default sizes, and the cell control bundle.
// ============================================================================
`default_nettype none
package bale_pkg;
    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_DUMP   = 3'd2;
    localparam logic [2:0] MODE_SEARCH = 3'd3;
    localparam logic [2:0] MODE_INSERT = 3'd4;
    localparam logic [2:0] MODE_DELETE = 3'd5;
    localparam logic [2:0] MODE_SORT   = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_POS   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // control broadcast to every cell in one cycle
    typedef struct packed {
        logic shift_up;   // cell takes lower neighbor (insert)
        logic shift_down; // cell takes upper neighbor (delete)
        logic rotate;     // whole row rotates down by one (dump/search walk)
        logic sort_even;  // compare-swap on even pairs
        logic sort_odd;   // compare-swap on odd pairs
    } cell_ctl_t;
endpackage
`default_nettype wire

>>> design/bale_cell.sv
// ============================================================================
// bale_cell: one list slot
// Holds one element; loads from a neighbor, the insert value, or its swap
// partner under broadcast control.
// ============================================================================
`default_nettype none
module bale_cell
    import bale_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                  clk,
    input  wire cell_ctl_t             ctl,
    input  wire logic                  sel_up,   // in shifted span: (target, len] insert, [target, len-1) delete
    input  wire logic                  sel_here, // index == target (insert)
    input  wire logic                  sort_lo,  // low member of active pair
    input  wire logic                  sort_hi,  // high member of active pair
    input  wire logic                  append_we,
    input  wire logic [DATA_WIDTH-1:0] ins_value,
    input  wire logic [DATA_WIDTH-1:0] below,
    input  wire logic [DATA_WIDTH-1:0] above,
    output logic      [DATA_WIDTH-1:0] elem
);
    logic [DATA_WIDTH-1:0] elem_reg, elem_next;
    logic                  swap;

    always_comb
    begin
        // low cell swaps when it is greater; high cell when lower is greater
        swap = 1'b0;
        if (sort_lo)
            swap = $signed(elem_reg) > $signed(above);
        else if (sort_hi)
            swap = $signed(below) > $signed(elem_reg);
        elem_next = elem_reg;
        if (append_we)
            elem_next = ins_value;
        else if (ctl.shift_up && sel_here)
            elem_next = ins_value;
        else if (ctl.shift_up && sel_up)
            elem_next = below;
        else if (ctl.shift_down && sel_up)
            elem_next = above;
        else if (ctl.rotate)
            elem_next = above;
        else if ((ctl.sort_even || ctl.sort_odd) && swap)
            elem_next = sort_lo ? above : below;
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem = elem_reg;
endmodule
`default_nettype wire

>>> design/bounded_array_list_engine.sv
// ============================================================================
// bounded_array_list_engine: list of signed words held in a row of cells
// Clear, append, dump, search, insert, delete and odd-even sort.
// ============================================================================
// Clear and error cases answer straight from idle; append, insert and delete
// answer from S_SHIFT; search rotates the row once around in S_WALK, then
// answers from S_OUT; dump streams one element per cycle while the output is
// free and holds the engine for a full rotation; sort runs CAPACITY odd-even
// passes, then answers from S_OUT. Output stalls hold S_SHIFT, S_OUT and dump.
// One request at a time. Reset clears length and control, not the elements.
`default_nettype none
module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // mode[2:0], value[34:3], position[40:35]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // status[2:0], data[34:3], location[40:35],
                                       // count[46:41]
    output logic             m_tlast
);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_SORT = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] len_reg, len_next, cnt_reg, cnt_next, tgt_reg, tgt_next;
    logic [2:0]  mode_reg, mode_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [31:0] key_reg, key_next;
    logic        found_reg, found_next;
    logic [CW-1:0] floc_reg, floc_next;
    logic        ovalid_reg, ovalid_next;
    logic [47:0] odata_reg, odata_next;
    logic        olast_reg, olast_next;
    logic        append_we;
    cell_ctl_t   ctl;
    logic [DATA_WIDTH-1:0] elem [CAPACITY];

    wire [2:0]  in_mode = s_tdata[2:0];
    wire [31:0] in_val  = s_tdata[34:3];
    wire [5:0]  in_pos  = s_tdata[40:35];
    wire        take    = s_tvalid && s_tready;
    wire        out_free = !ovalid_reg || m_tready;
    wire [DATA_WIDTH-1:0] head = elem[0];
    // sign-extend then trim the head element to 32 bits
    wire [63:0] head_ext = 64'($signed(head));
    wire [63:0] in_ext   = 64'($signed(in_val));
    wire [6:0]  pos7     = {1'b0, in_pos};
    wire [6:0]  len7     = 7'(len_reg);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);
            bale_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .sel_up   (ctl.shift_up ? (IDX > tgt_reg && IDX <= len_reg)
                                        : (IDX >= tgt_reg && IDX + 1'b1 < len_reg)),
                .sel_here (IDX == tgt_reg),
                .sort_lo  ((g % 2 == 0 ? ctl.sort_even : ctl.sort_odd)
                           && g + 1 < CAPACITY && IDX + 1'b1 < len_reg),
                .sort_hi  ((g % 2 == 1 ? ctl.sort_even : ctl.sort_odd) && g > 0
                           && IDX < len_reg),
                .append_we(append_we && IDX == len_reg),
                .ins_value(val_reg),
                .below    (elem[(g + CAPACITY - 1) % CAPACITY]),
                .above    (elem[(g + 1) % CAPACITY]),
                .elem     (elem[g])
            );
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE) && out_free;

    // pack a result transaction
    function automatic logic [47:0] pack(input logic [2:0] st, input logic [31:0] d,
                                         input logic [CW-1:0] loc,
                                         input logic [CW-1:0] cn);
        pack = {1'b0, 6'(cn), 6'(loc), d, st};
    endfunction

    always_comb
    begin
        state_next = state_reg; len_next = len_reg; cnt_next = cnt_reg;
        tgt_next = tgt_reg; mode_next = mode_reg; val_next = val_reg;
        key_next = key_reg; found_next = found_reg; floc_next = floc_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next = odata_reg; olast_next = olast_reg;
        append_we = 1'b0;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    mode_next = in_mode;
                    val_next  = in_ext[DATA_WIDTH-1:0];
                    key_next  = in_val;
                    tgt_next  = CW'(in_pos - 6'd1);
                    cnt_next  = '0;
                    found_next = 1'b0;
                    floc_next = '0;
                    olast_next = 1'b1;
                    case (in_mode)
                        MODE_CLEAR:
                        begin
                            len_next = '0; ovalid_next = 1'b1;
                            odata_next = pack(ST_OK, '0, '0, '0);
                        end
                        MODE_APPEND:
                        begin
                            ovalid_next = 1'b1;
                            if (len_reg >= CW'(CAPACITY))
                                odata_next = pack(ST_FULL, '0, '0, len_reg);
                            else
                                state_next = S_SHIFT; // write in S_SHIFT once the output is free
                        end
                        MODE_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                ovalid_next = 1'b1;
                                odata_next = pack(ST_EMPTY, '0, '0, '0);
                            end
                            else
                                state_next = S_WALK;
                        end
                        MODE_SEARCH: state_next = S_WALK;
                        MODE_INSERT:
                        begin
                            ovalid_next = 1'b1;
                            if (len_reg >= CW'(CAPACITY))
                                odata_next = pack(ST_FULL, '0, '0, len_reg);
                            else if (pos7 < 7'd1 || pos7 > len7 + 7'd1)
                                odata_next = pack(ST_BAD_POS, '0, '0, len_reg);
                            else
                            begin
                                ovalid_next = ovalid_reg && !m_tready;
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_DELETE:
                        begin
                            ovalid_next = 1'b1;
                            if (len_reg == '0)
                                odata_next = pack(ST_EMPTY, '0, '0, '0);
                            else if (pos7 < 7'd1 || pos7 > len7)
                                odata_next = pack(ST_BAD_POS, '0, '0, len_reg);
                            else
                            begin
                                ovalid_next = ovalid_reg && !m_tready;
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_SORT: state_next = S_SORT;
                        default: olast_next = olast_reg;
                    endcase
                    // append emits its result from S_SHIFT
                    if (in_mode == MODE_APPEND && len_reg < CW'(CAPACITY))
                        ovalid_next = ovalid_reg && !m_tready;
                end
            end
            S_SHIFT:
            begin
                // delete reads the removed element from the row while shifting
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                    case (mode_reg)
                        MODE_APPEND:
                        begin
                            append_we = 1'b1;
                            len_next = len_reg + 1'b1;
                            odata_next = pack(ST_OK, '0, '0, len_reg + 1'b1);
                        end
                        MODE_INSERT:
                        begin
                            ctl.shift_up = 1'b1;
                            len_next = len_reg + 1'b1;
                            odata_next = pack(ST_OK, '0, '0, len_reg + 1'b1);
                        end
                        default:
                        begin
                            ctl.shift_down = 1'b1;
                            len_next = len_reg - 1'b1;
                            odata_next = pack(ST_OK,
                                32'(64'($signed(elem[tgt_reg[$clog2(CAPACITY)-1:0]]))),
                                '0, len_reg - 1'b1);
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // row rotates one place a cycle (in dump only while the output is free); head visits every entry once
                if (mode_reg == MODE_DUMP)
                begin
                    if (out_free)
                    begin
                        ctl.rotate = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg < len_reg)
                        begin
                            ovalid_next = 1'b1;
                            olast_next = (cnt_reg + 1'b1 == len_reg);
                            odata_next = pack(ST_OK, head_ext[31:0], cnt_reg + 1'b1,
                                              len_reg);
                        end
                        if (cnt_reg + 1'b1 == CW'(CAPACITY))
                            state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.rotate = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (!found_reg && cnt_reg < len_reg && head == val_reg)
                    begin
                        found_next = 1'b1;
                        floc_next = cnt_reg + 1'b1;
                    end
                    if (cnt_reg + 1'b1 == CW'(CAPACITY))
                        state_next = S_OUT;
                end
            end
            S_SORT:
            begin
                // pairs beyond the length never swap: upper entries are masked
                ctl.sort_even = !cnt_reg[0];
                ctl.sort_odd  = cnt_reg[0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == CW'(CAPACITY))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                    if (mode_reg == MODE_SORT)
                        odata_next = pack(ST_OK, '0, '0, len_reg);
                    else
                        odata_next = pack(found_reg ? ST_OK : ST_NOT_FOUND, key_reg,
                                          floc_reg, len_reg);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next; mode_reg <= mode_next; val_reg <= val_next;
        key_reg <= key_next; found_reg <= found_next; floc_reg <= floc_next;
        odata_reg <= odata_next; olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
endmodule
`default_nettype wire

>>> verif/tb_bounded_array_list_engine.sv
// ============================================================================
// tb_bounded_array_list_engine: self-checking bench for the list engine
// Drives list requests with random gaps and output stalls, predicts every
// result from a behavioral copy of the list, and compares field by field.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

import bale_pkg::*;

typedef struct {
    logic [2:0]  status;
    logic [31:0] data;
    logic [5:0]  location;
    logic [5:0]  count;
    logic        last;
} list_rsp_t;

class list_scoreboard;
    logic signed [31:0] elems[32];
    int unsigned        len;
    list_rsp_t          pending[$];
    int                 mismatches;

    function new();
        len = 0;
        mismatches = 0;
    endfunction

    function void push(logic [2:0] st, logic [31:0] d, logic [5:0] loc, logic lst);
        list_rsp_t r;
        r.status = st; r.data = d; r.location = loc; r.count = len[5:0]; r.last = lst;
        pending.push_back(r);
    endfunction

    // Predict results of one accepted request
    function void note_request(logic [2:0] mode, logic signed [31:0] val, logic [5:0] pos);
        logic signed [31:0] removed;
        logic signed [31:0] key;
        int                 j;
        bit                 hit;
        case (mode)
            MODE_CLEAR:
            begin
                len = 0;
                push(ST_OK, 0, 0, 1);
            end
            MODE_APPEND:
            begin
                if (len >= 32) push(ST_FULL, 0, 0, 1);
                else
                begin
                    elems[len] = val;
                    len++;
                    push(ST_OK, 0, 0, 1);
                end
            end
            MODE_DUMP:
            begin
                if (len == 0) push(ST_EMPTY, 0, 0, 1);
                else
                    for (int i = 0; i < len; i++)
                        push(ST_OK, elems[i], 6'(i + 1), (i + 1) == len);
            end
            MODE_SEARCH:
            begin
                hit = 0;
                for (int i = 0; i < len && !hit; i++)
                    if (elems[i] == val)
                    begin
                        hit = 1;
                        push(ST_OK, val, 6'(i + 1), 1);
                    end
                if (!hit) push(ST_NOT_FOUND, val, 0, 1);
            end
            MODE_INSERT:
            begin
                if (len >= 32) push(ST_FULL, 0, 0, 1);
                else if (pos < 1 || pos > len + 1) push(ST_BAD_POS, 0, 0, 1);
                else
                begin
                    for (int i = len; i >= pos; i--) elems[i] = elems[i - 1];
                    elems[pos - 1] = val;
                    len++;
                    push(ST_OK, 0, 0, 1);
                end
            end
            MODE_DELETE:
            begin
                if (len == 0) push(ST_EMPTY, 0, 0, 1);
                else if (pos < 1 || pos > len) push(ST_BAD_POS, 0, 0, 1);
                else
                begin
                    removed = elems[pos - 1];
                    for (int i = pos - 1; i + 1 < len; i++) elems[i] = elems[i + 1];
                    len--;
                    push(ST_OK, removed, 0, 1);
                end
            end
            MODE_SORT:
            begin
                for (int i = 1; i < len; i++)
                begin
                    key = elems[i];
                    j = i;
                    while (j > 0 && elems[j - 1] > key)
                    begin
                        elems[j] = elems[j - 1];
                        j--;
                    end
                    elems[j] = key;
                end
                push(ST_OK, 0, 0, 1);
            end
            default: ;  // unused code: no result
        endcase
    endfunction

    function void check_result(logic [47:0] td, logic tl);
        list_rsp_t e;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %h last=%b", td, tl);
            return;
        end
        e = pending.pop_front();
        if (td[2:0] !== e.status || td[34:3] !== e.data || td[40:35] !== e.location ||
            td[46:41] !== e.count || tl !== e.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp st=%0d d=%h loc=%0d cnt=%0d last=%b",
                          " | got st=%0d d=%h loc=%0d cnt=%0d last=%b"},
                         e.status, e.data, e.location, e.count, e.last,
                         td[2:0], td[34:3], td[40:35], td[46:41], tl);
        end
    endfunction
endclass

module tb_bounded_array_list_engine;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    list_scoreboard sb;
    int unsigned    cycles = 0;
    bit             stim_done = 0;

    localparam int CYCLE_LIMIT = 600000;

    always #1 clk = ~clk;

    bounded_array_list_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Mostly short gaps, occasionally long ones, and runs with none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request; returns after the transaction is accepted.
    // tvalid stays high into a back-to-back request and drops only for a gap.
    task automatic send_request(logic [2:0] mode, logic [31:0] val, logic [5:0] pos);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'd0, pos, val, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(mode, val, pos);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 7)) - 32'd3;  // small, repeats likely
            default: return $urandom();
        endcase
    endfunction

    // Position biased toward the valid range, sometimes out of it
    function automatic logic [5:0] rand_pos();
        if ($urandom_range(0, 9) == 0) return 6'($urandom());
        return 6'($urandom_range(1, sb.len + 1));
    endfunction

    // Output side: random stalls, check every transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            m_tready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] m;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty-list cases, extremes, fill to full, all modes
        send_request(MODE_DUMP,   0, 0);
        send_request(MODE_DELETE, 0, 1);
        send_request(MODE_SEARCH, 32'h1234_5678, 0);
        send_request(MODE_SORT,   0, 0);
        send_request(MODE_INSERT, 32'h7fff_ffff, 2);   // bad position
        send_request(MODE_INSERT, 32'h8000_0000, 1);
        send_request(MODE_APPEND, 32'h7fff_ffff, 0);
        send_request(MODE_APPEND, 32'hffff_ffff, 0);
        send_request(MODE_SEARCH, 32'hffff_ffff, 0);
        send_request(MODE_DELETE, 0, 6'h3f);            // bad position
        send_request(MODE_DELETE, 0, 0);                // bad position
        send_request(3'd7, 32'hffff_ffff, 6'h3f);       // unused code
        send_request(MODE_SORT,   0, 0);
        send_request(MODE_DUMP,   0, 0);
        for (int i = 0; i < 29; i++) send_request(MODE_APPEND, $urandom(), 0);
        send_request(MODE_APPEND, 32'h5555_aaaa, 0);    // full
        send_request(MODE_INSERT, 32'haaaa_5555, 1);    // full
        send_request(MODE_SORT,   0, 0);
        send_request(MODE_DUMP,   0, 0);
        send_request(MODE_DELETE, 0, 32);
        send_request(MODE_INSERT, 32'h0, 32);
        send_request(MODE_CLEAR,  0, 0);

        // Random: build and edit lists, with occasional clears and dumps
        for (int n = 0; n < 500; n++)
        begin
            case ($urandom_range(0, 19))
                0:       m = MODE_CLEAR;
                1, 2:    m = MODE_DUMP;
                3, 4, 5: m = MODE_SEARCH;
                6, 7, 8: m = MODE_INSERT;
                9, 10:   m = MODE_DELETE;
                11:      m = MODE_SORT;
                12:      m = 3'd7;
                default: m = MODE_APPEND;
            endcase
            if (m == MODE_SEARCH && sb.len > 0 && $urandom_range(0, 1))
                send_request(m, sb.elems[$urandom_range(0, sb.len - 1)], 6'($urandom()));
            else if (m == MODE_INSERT || m == MODE_DELETE)
                send_request(m, rand_value(), rand_pos());
            else
                send_request(m, rand_value(), 6'($urandom()));
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
